/* design/assert_macros.svh */
// Assertion macros shared by the subset/superset transform RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define SSZT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSZT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SSZT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SSZT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/sszt_pkg.sv */
// Types and constants shared by the subset/superset transform block.
`default_nettype none

package sszt_pkg;

    localparam int MAX_BITS_DEF = 10;

    localparam int ACTION_W   = 2;
    localparam int INDEX_W    = 10;
    localparam int VALUE_W    = 64;
    localparam int CFG_DATA_W = 4;
    localparam int CFG_IDX_W  = 1;

    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_RUN   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_IN_USE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] BITS_IN_USE_RST = 4'd10;

    typedef struct packed {
        logic [ACTION_W-1:0]       action;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [ACTION_W-1:0]       action_done;
    } out_t;

endpackage

`default_nettype wire

/* design/sszt_pair_gen.sv */
// Pair address generator: maps a pair counter and bit position to the two table indexes.
`default_nettype none

module sszt_pair_gen #(
    parameter int AW = 10,
    parameter int BW = 4
) (
    input  wire logic [BW-1:0] bit_idx,
    input  wire logic [AW-1:0] pair_idx,
    input  wire logic [BW-1:0] nb,
    output logic [AW-1:0]      m_addr,
    output logic [AW-1:0]      partner_addr,
    output logic               last_pair,
    output logic               last_bit
);

    logic [AW-1:0] sel;
    logic [AW-1:0] lo_mask;
    logic [AW:0]   span;
    logic [AW-1:0] half_m1;

    always_comb
    begin
        sel          = AW'(1) << bit_idx;
        lo_mask      = sel - AW'(1);
        m_addr       = ((pair_idx & ~lo_mask) << 1) | sel | (pair_idx & lo_mask);
        partner_addr = m_addr ^ sel;
        span         = (AW+1)'(1) << nb;
        half_m1      = AW'((span >> 1) - (AW+1)'(1));
        last_pair    = (pair_idx == half_m1);
        last_bit     = ((bit_idx + BW'(1)) == nb);
    end

endmodule

`default_nettype wire

/* design/subset_superset_zeta_transform.sv */
// Top level of the subset/superset zeta transform block: handshake, sequencer and table.
`default_nettype none
`include "assert_macros.svh"

// The block keeps a table of 2^MAX_BITS signed 64-bit entries indexed by bitmask and takes
// one action per transaction: write an entry, read an entry (a registered table read), or
// run the transform over the 2^nb entries in use, nb = min(bits_in_use, MAX_BITS). A run
// visits each bit position from bit 0 up and, for each of the 2^(nb-1) index pairs that
// differ in that bit, reads both entries in state ST_PAIR_RD and writes their sum through
// the single 64-bit adder and table write port in the next state, ST_PAIR_WR; with nb of 0
// a run visits no pair and returns its result directly. Sums wrap modulo 2^64. Direction 0
// adds submasks into their supermasks, direction 1 the reverse. Index bits at or above nb
// are ignored. Entries start undefined; write every entry in use before running or reading.
// Change direction and bits_in_use only while idle.
module subset_superset_zeta_transform #(
    parameter int MAX_BITS = sszt_pkg::MAX_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire sszt_pkg::in_t                     in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output sszt_pkg::out_t                         out_data,
    input  wire logic                              cfg_we,
    input  wire logic [sszt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sszt_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    import sszt_pkg::*;

    localparam int AW    = MAX_BITS;
    localparam int BW    = $clog2(MAX_BITS + 1);
    localparam int DEPTH = 1 << MAX_BITS;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_RD_WAIT = 4'b0010,
        ST_PAIR_RD = 4'b0100,
        ST_PAIR_WR = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic                   direction_reg;
    logic [CFG_DATA_W-1:0]  bits_reg;
    logic [BW-1:0]          bit_reg, bit_next;
    logic [AW-1:0]          pair_reg, pair_next;
    logic                   out_valid_reg, out_valid_next;
    out_t                   out_data_reg, out_data_next;

    logic [BW-1:0]          eff_bits;
    logic [AW:0]            span;
    logic [AW-1:0]          idx_addr;
    logic [AW-1:0]          m_addr;
    logic [AW-1:0]          partner_addr;
    logic                   last_pair;
    logic                   last_bit;
    logic                   in_fire;

    logic [VALUE_W-1:0]     mem [DEPTH];
    logic [VALUE_W-1:0]     q_a_reg;
    logic [VALUE_W-1:0]     q_b_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_W-1:0]     mem_wdata;
    logic [AW-1:0]          rd_addr_a;

    always_comb
    begin
        eff_bits = (32'(bits_reg) > 32'(MAX_BITS)) ? BW'(MAX_BITS) : BW'(bits_reg);
        span     = (AW+1)'(1) << eff_bits;
        idx_addr = AW'(in_data.index) & AW'(span - (AW+1)'(1));
    end

    sszt_pair_gen #(
        .AW (AW),
        .BW (BW)
    ) u_pair_gen (
        .bit_idx      (bit_reg),
        .pair_idx     (pair_reg),
        .nb           (eff_bits),
        .m_addr       (m_addr),
        .partner_addr (partner_addr),
        .last_pair    (last_pair),
        .last_bit     (last_bit)
    );

    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            bits_reg      <= BITS_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIRECTION:   direction_reg <= cfg_wdata[0];
                REG_BITS_IN_USE: bits_reg      <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = in_data.value;
        rd_addr_a = (state_reg == ST_IDLE) ? idx_addr : m_addr;
        if (state_reg == ST_PAIR_WR)
        begin
            mem_we    = 1'b1;
            mem_waddr = direction_reg ? partner_addr : m_addr;
            mem_wdata = q_a_reg + q_b_reg;
        end
        else if (in_fire && (in_data.action == ACT_WRITE))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        q_a_reg <= mem[rd_addr_a];
        q_b_reg <= mem[partner_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        bit_next       = bit_reg;
        pair_next      = pair_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    out_data_next.read_value  = '0;
                    out_data_next.action_done = in_data.action;
                    unique case (in_data.action)
                        ACT_READ:
                        begin
                            state_next = ST_RD_WAIT;
                        end
                        ACT_RUN:
                        begin
                            bit_next  = '0;
                            pair_next = '0;
                            if (eff_bits != '0)
                            begin
                                state_next = ST_PAIR_RD;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                out_valid_next            = 1'b1;
                out_data_next.read_value  = q_a_reg;
                out_data_next.action_done = ACT_READ;
                state_next                = ST_IDLE;
            end
            ST_PAIR_RD:
            begin
                state_next = ST_PAIR_WR;
            end
            ST_PAIR_WR:
            begin
                state_next = ST_PAIR_RD;
                if (last_pair)
                begin
                    pair_next = '0;
                    if (last_bit)
                    begin
                        state_next                = ST_IDLE;
                        out_valid_next            = 1'b1;
                        out_data_next.read_value  = '0;
                        out_data_next.action_done = ACT_RUN;
                    end
                    else
                    begin
                        bit_next = bit_reg + BW'(1);
                    end
                end
                else
                begin
                    pair_next = pair_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_reg       <= '0;
            pair_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_reg       <= bit_next;
            pair_reg      <= pair_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `SSZT_ASSERT_IMPL(a_no_result_mid_run, clk, rst_n, (state_reg == ST_PAIR_RD) || (state_reg == ST_PAIR_WR), !out_valid_reg)
    `SSZT_ASSERT_NEXT(a_read_result_next, clk, rst_n, in_fire && (in_data.action == ACT_READ), (state_reg == ST_RD_WAIT) ##1 out_valid_reg)
    `SSZT_ASSERT_IMPL(a_wr_after_rd, clk, rst_n, state_reg == ST_PAIR_WR, $past(state_reg) == ST_PAIR_RD)
    `SSZT_ASSERT_IMPL(a_bit_in_range, clk, rst_n, state_reg == ST_PAIR_RD, bit_reg < eff_bits)

endmodule

`default_nettype wire

/* verif/subset_superset_zeta_transform_test.sv */
// Self-checking testbench for the subset/superset zeta transform block.
`default_nettype none

module subset_superset_zeta_transform_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sszt_pkg::*;

    localparam int TB_AW = MAX_BITS_DEF;
    localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

    typedef struct {
        in_t         item;
        int unsigned gap;
    } queued_action_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    queued_action_t pending_items[$];
    out_t expected_results[$];
    logic [VALUE_W-1:0] mask_sums [0:(1 << MAX_BITS_DEF)-1];
    bit [(1 << MAX_BITS_DEF)-1:0] entry_known = '0;

    logic cfg_dir = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_bits = BITS_IN_USE_RST;
    bit calm = 1'b0;
    int unsigned idle_count = 0;
    int unsigned stall_left = 0;
    int n_write = 0;
    int n_run = 0;
    int n_read = 0;
    int n_unused = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_settings = 0;

    subset_superset_zeta_transform uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic int unsigned active_bits();
        return (cfg_bits > MAX_BITS_DEF) ? MAX_BITS_DEF : int'(cfg_bits);
    endfunction

    function automatic out_t apply_action(in_t t);
        out_t r;
        int unsigned span;
        int unsigned idx;
        int unsigned sel;
        logic [TB_AW-1:0] slot;
        logic [TB_AW-1:0] hi_slot;
        logic [TB_AW-1:0] lo_slot;
        span = 1 << active_bits();
        idx = t.index & (span - 1);
        slot = idx[TB_AW-1:0];
        r.read_value = '0;
        r.action_done = t.action;
        case (t.action)
            ACT_WRITE:
            begin
                mask_sums[slot] = t.value;
                n_write++;
            end
            ACT_RUN:
            begin
                for (int unsigned b = 0; b < active_bits(); b++)
                begin
                    sel = 1 << b;
                    for (int unsigned m = 0; m < span; m++)
                    begin
                        if ((m & sel) != 0)
                        begin
                            hi_slot = m[TB_AW-1:0];
                            lo_slot = hi_slot ^ sel[TB_AW-1:0];
                            if (cfg_dir == 1'b0)
                                mask_sums[hi_slot] = mask_sums[hi_slot] + mask_sums[lo_slot];
                            else
                                mask_sums[lo_slot] = mask_sums[lo_slot] + mask_sums[hi_slot];
                        end
                    end
                end
                n_run++;
            end
            ACT_READ:
            begin
                r.read_value = mask_sums[slot];
                n_read++;
            end
            default:
                n_unused++;
        endcase
        return r;
    endfunction

    // hold the payload until accepted, then advance after the drawn gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            idle_count <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_results.push_back(apply_action(in_data));
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() != 0 && idle_count >= pending_items[0].gap)
                begin
                    in_data <= pending_items[0].item;
                    in_valid <= 1'b1;
                    idle_count <= 0;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    in_valid <= 1'b0;
                    idle_count <= (pending_items.size() != 0) ? idle_count + 1 : 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        int unsigned stall_next;
        out_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                n_checked++;
                if (expected_results.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected transaction, got value %h action %0d",
                             $time, out_data.read_value, out_data.action_done);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.read_value !== want.read_value)
                    begin
                        n_errors++;
                        $display("%0t: read_value expected %h got %h",
                                 $time, want.read_value, out_data.read_value);
                    end
                    if (out_data.action_done !== want.action_done)
                    begin
                        n_errors++;
                        $display("%0t: action_done expected %0d got %0d",
                                 $time, want.action_done, out_data.action_done);
                    end
                end
                stall_next = calm ? 0 : $urandom_range(0, 6);
            end
            else
                stall_next = (stall_left > 0) ? stall_left - 1 : 0;
            stall_left <= stall_next;
            out_ready <= (stall_next == 0);
        end
    end

    task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == REG_DIRECTION)
            cfg_dir = data[0];
        else
            cfg_bits = data;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(logic dir, logic [CFG_DATA_W-1:0] nbits);
        settle();
        program_reg(REG_DIRECTION, {{(CFG_DATA_W-1){1'b0}}, dir});
        program_reg(REG_BITS_IN_USE, nbits);
        n_settings++;
    endtask

    task automatic queue_action(logic [ACTION_W-1:0] act, int unsigned index,
                                logic [VALUE_W-1:0] value);
        queued_action_t q;
        int unsigned slot;
        q.item.action = act;
        q.item.index = index[INDEX_W-1:0];
        q.item.value = value;
        q.gap = calm ? 0 : $urandom_range(0, 6);
        slot = index & ((1 << active_bits()) - 1);
        if (act == ACT_WRITE)
            entry_known[slot[TB_AW-1:0]] = 1'b1;
        pending_items.push_back(q);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return {1'b0, {(VALUE_W-1){1'b1}}};
            1: return {1'b1, {(VALUE_W-1){1'b0}}};
            2: return '1;
            3: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int unsigned spread_index(int unsigned entry);
        int unsigned lowmask;
        lowmask = (1 << active_bits()) - 1;
        return (entry & lowmask) | ($urandom_range(0, 1023) & ~lowmask);
    endfunction

    task automatic fill_unknown(bit all_entries);
        for (int unsigned m = 0; m < (1 << active_bits()); m++)
            if (all_entries || !entry_known[m[TB_AW-1:0]])
                queue_action(ACT_WRITE, spread_index(m), pick_value());
    endtask

    task automatic random_mix(int count);
        int unsigned pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_action(ACT_WRITE, $urandom_range(0, 1023), pick_value());
            else if (pick < 80)
                queue_action(ACT_READ, $urandom_range(0, 1023), {$urandom, $urandom});
            else if (pick < 92)
                queue_action(ACT_RUN, $urandom_range(0, 1023), {$urandom, $urandom});
            else
                queue_action(ACT_SPARE, $urandom_range(0, 1023), {$urandom, $urandom});
        end
    endtask

    initial
    begin
        int unsigned wide_index;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        set_mode(1'b0, 4'd2);
        queue_action(ACT_WRITE, 0, {1'b0, {(VALUE_W-1){1'b1}}});
        queue_action(ACT_WRITE, 1, {1'b1, {(VALUE_W-1){1'b0}}});
        queue_action(ACT_WRITE, 'h3FE, '1);
        queue_action(ACT_WRITE, 'h3FF, 64'd1);
        queue_action(ACT_READ, 0, '0);
        queue_action(ACT_READ, 'h3FD, '1);
        queue_action(ACT_READ, 2, '0);
        queue_action(ACT_SPARE, 'h3FF, '1);
        queue_action(ACT_READ, 3, '0);
        queue_action(ACT_RUN, 0, '0);
        for (int unsigned m = 0; m < 4; m++)
            queue_action(ACT_READ, m, '0);

        set_mode(1'b1, 4'd2);
        queue_action(ACT_RUN, 'h3FF, '1);
        queue_action(ACT_READ, 0, '0);
        queue_action(ACT_READ, 3, '0);

        set_mode(1'b1, 4'd0);
        queue_action(ACT_WRITE, 'h3FF, 64'd5);
        queue_action(ACT_RUN, 0, '0);
        queue_action(ACT_READ, 'h200, '0);
        queue_action(ACT_SPARE, 0, '0);

        repeat (11)
        begin
            calm = ($urandom_range(0, 3) == 0);
            set_mode(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 6)));
            fill_unknown(1'b0);
            random_mix(40);
        end

        calm = 1'b0;
        set_mode(1'b0, 4'd15);
        repeat (20)
        begin
            wide_index = $urandom_range(0, 1023);
            queue_action(ACT_WRITE, wide_index, pick_value());
            queue_action(ACT_READ, wide_index, '0);
        end

        calm = 1'b1;
        set_mode(1'b0, 4'd1);
        random_mix(20);

        settle();
        repeat (20) @(posedge clk);
        $display("Checked %0d transactions: %0d writes, %0d runs, %0d reads, %0d unused codes",
                 n_checked, n_write, n_run, n_read, n_unused);
        $display("Used %0d register settings, %0d mismatches", n_settings, n_errors);
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timeout at %0t with %0d transactions outstanding", $time,
                 expected_results.size() + pending_items.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
